### src/ipap_pkg.sv
// Shared types and constants for the IPv4 address and port text parser.
`timescale 1ns / 1ps

package ipap_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Limits
    localparam int unsigned OCTET_COUNT       = 4;
    localparam int unsigned PORT_DIGITS_LIMIT = 6;
    localparam int unsigned OCTET_MAX         = 255;
    localparam int unsigned PORT_MAX          = 65535;

    localparam int unsigned ACC_W  = 17;
    localparam int unsigned PROD_W = 20;
    localparam int unsigned CNT_W  = 3;

    localparam logic [1:0]       LAST_OCTET     = 2'(OCTET_COUNT - 1);
    localparam logic [CNT_W-1:0] OCTET_DIGITS   = CNT_W'(OCTET_COUNT - 1);
    localparam logic [CNT_W-1:0] PORT_DIGITS    = CNT_W'(PORT_DIGITS_LIMIT - 1);
    localparam logic [PROD_W-1:0] OCTET_LIMIT   = PROD_W'(OCTET_MAX);
    localparam logic [PROD_W-1:0] PORT_LIMIT    = PROD_W'(PORT_MAX);

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_OCTET = 4'b0001,
        PH_PORT  = 4'b0010,
        PH_DONE  = 4'b0100,
        PH_FAIL  = 4'b1000
    } phase_t;

    // Request payloads
    typedef struct packed {
        logic [7:0] ch;
    } ipap_in_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
        logic [15:0] port_number;
    } ipap_out_t;

endpackage

### src/ipap_chan_if.sv
// Valid/ready channel interface carrying one request payload.
`timescale 1ns / 1ps

interface ipap_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/ipv4_address_port_text_parser.sv
// Top level: character-serial IPv4 "a.b.c.d:port" text parser.
// The result of a NUL request is registered: it appears in the output register in the cycle after accept.
// Throughput: one character per cycle; the parse state is updated in a single pass.
// A result that is not taken holds off further characters until it drains.
// Reset (rst_n low, async): octet phase, counters and address cleared, output empty.
`timescale 1ns / 1ps

module ipv4_address_port_text_parser (
    input  logic         clk,
    input  logic         rst_n,
    ipap_chan_if.sink    chars,
    ipap_chan_if.source  result
);
    import ipap_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [1:0]            octet_index_reg, octet_index_next;
    logic [CNT_W-1:0]      digit_count_reg, digit_count_next;
    logic [ACC_W-1:0]      accumulator_reg, accumulator_next;
    logic [31:0]           address_reg, address_next;
    logic                  out_valid_reg, out_valid_next;
    ipap_out_t             out_data_reg, out_data_next;

    logic                  accept;
    logic [7:0]            c;
    logic                  is_digit;
    logic [PROD_W-1:0]     acc_ext;
    logic [PROD_W-1:0]     product;
    logic                  good;

    // Accept whenever the output register is free or being drained
    assign chars.ready = !out_valid_reg || result.ready;
    assign accept      = chars.valid && chars.ready;
    assign c           = chars.data.ch;
    assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);

    // accumulator * 10 + digit
    assign acc_ext = PROD_W'(accumulator_reg);
    assign product = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(c - CH_ZERO);

    assign good = (phase_reg == PH_DONE) ||
                  ((phase_reg == PH_PORT) && (digit_count_reg != '0));

    // Parse state update
    always_comb
    begin
        phase_next       = phase_reg;
        octet_index_next = octet_index_reg;
        digit_count_next = digit_count_reg;
        accumulator_next = accumulator_reg;
        address_next     = address_reg;
        if (accept)
        begin
            if (c == CH_NUL)
            begin
                phase_next       = PH_OCTET;
                octet_index_next = '0;
                digit_count_next = '0;
                accumulator_next = '0;
                address_next     = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_OCTET:
                    begin
                        if (is_digit)
                        begin
                            if (digit_count_reg >= OCTET_DIGITS || product > OCTET_LIMIT)
                                phase_next = PH_FAIL;
                            else
                            begin
                                accumulator_next = ACC_W'(product);
                                digit_count_next = digit_count_reg + 1'b1;
                            end
                        end
                        else if (c == CH_DOT)
                        begin
                            if (octet_index_reg == LAST_OCTET)
                                phase_next = PH_FAIL;
                            else
                            begin
                                address_next     = {address_reg[23:0], accumulator_reg[7:0]};
                                octet_index_next = octet_index_reg + 1'b1;
                                accumulator_next = '0;
                                digit_count_next = '0;
                            end
                        end
                        else if (c == CH_COLON)
                        begin
                            if (octet_index_reg != LAST_OCTET)
                                phase_next = PH_FAIL;
                            else
                            begin
                                address_next     = {address_reg[23:0], accumulator_reg[7:0]};
                                accumulator_next = '0;
                                digit_count_next = '0;
                                phase_next       = PH_PORT;
                            end
                        end
                        else
                            phase_next = PH_FAIL;
                    end
                    PH_PORT:
                    begin
                        if (is_digit)
                        begin
                            if (digit_count_reg >= PORT_DIGITS || product > PORT_LIMIT)
                                phase_next = PH_FAIL;
                            else
                            begin
                                accumulator_next = ACC_W'(product);
                                digit_count_next = digit_count_reg + 1'b1;
                            end
                        end
                        else if (c == CH_SLASH)
                            phase_next = (digit_count_reg == '0) ? PH_FAIL : PH_DONE;
                        else
                            phase_next = PH_FAIL;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (accept && c == CH_NUL)
        begin
            out_valid_next            = 1'b1;
            out_data_next.ok          = good;
            out_data_next.address     = good ? address_reg : '0;
            out_data_next.port_number = good ? accumulator_reg[15:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_OCTET;
            octet_index_reg <= '0;
            digit_count_reg <= '0;
            accumulator_reg <= '0;
            address_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            octet_index_reg <= octet_index_next;
            digit_count_reg <= digit_count_next;
            accumulator_reg <= accumulator_next;
            address_reg     <= address_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

### tb/ipv4_address_port_text_parser_tb.sv
// Self-checking testbench for the IPv4 address and port text parser.
`timescale 1ns / 1ps

module ipv4_address_port_text_parser_tb;
    import ipap_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    ipap_chan_if #(.payload_t(ipap_in_t))  chars_if ();
    ipap_chan_if #(.payload_t(ipap_out_t)) result_if ();

    ipv4_address_port_text_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if)
    );

    // Mirror of the parse state
    phase_t           ps_phase;
    logic [1:0]       ps_octet;
    logic [CNT_W-1:0] ps_digits;
    logic [ACC_W-1:0] ps_acc;
    logic [31:0]      ps_addr;

    ipap_out_t   expected_results[$];
    logic [7:0]  text_q[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned chars_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void clear_parse();
        ps_phase  = PH_OCTET;
        ps_octet  = '0;
        ps_digits = '0;
        ps_acc    = '0;
        ps_addr   = '0;
    endfunction

    // Advance the parse mirror by one accepted character; a NUL queues a result
    function automatic void parse_char(logic [7:0] c);
        ipap_out_t   res;
        int unsigned val;
        logic        is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        val = ps_acc * 10 + (c - CH_ZERO);
        if (c == CH_NUL)
        begin
            res.ok          = (ps_phase == PH_DONE) || (ps_phase == PH_PORT && ps_digits != 0);
            res.address     = res.ok ? ps_addr : '0;
            res.port_number = res.ok ? ps_acc[15:0] : '0;
            expected_results.push_back(res);
            clear_parse();
        end
        else if (ps_phase == PH_OCTET)
        begin
            if (is_digit)
            begin
                if (ps_digits >= OCTET_DIGITS || val > OCTET_MAX)
                    ps_phase = PH_FAIL;
                else
                begin
                    ps_acc    = ACC_W'(val);
                    ps_digits = ps_digits + 1'b1;
                end
            end
            else if (c == CH_DOT)
            begin
                if (ps_octet == LAST_OCTET)
                    ps_phase = PH_FAIL;
                else
                begin
                    ps_addr   = {ps_addr[23:0], ps_acc[7:0]};
                    ps_octet  = ps_octet + 1'b1;
                    ps_acc    = '0;
                    ps_digits = '0;
                end
            end
            else if (c == CH_COLON)
            begin
                if (ps_octet != LAST_OCTET)
                    ps_phase = PH_FAIL;
                else
                begin
                    ps_addr   = {ps_addr[23:0], ps_acc[7:0]};
                    ps_acc    = '0;
                    ps_digits = '0;
                    ps_phase  = PH_PORT;
                end
            end
            else
                ps_phase = PH_FAIL;
        end
        else if (ps_phase == PH_PORT)
        begin
            if (is_digit)
            begin
                if (ps_digits >= PORT_DIGITS || val > PORT_MAX)
                    ps_phase = PH_FAIL;
                else
                begin
                    ps_acc    = ACC_W'(val);
                    ps_digits = ps_digits + 1'b1;
                end
            end
            else if (c == CH_SLASH)
                ps_phase = (ps_digits == 0) ? PH_FAIL : PH_DONE;
            else
                ps_phase = PH_FAIL;
        end
    endfunction

    // Result receiver: random stalls, or a counted hold-off when requested
    initial
    begin : result_sink
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
                result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_result
        ipap_out_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: ok %0d address %08h port_number %0d",
                       result_if.data.ok, result_if.data.address, result_if.data.port_number);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_if.data.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, result_if.data.ok);
                    mismatches++;
                end
                if (result_if.data.address !== want.address)
                begin
                    $error("address: expected %08h, got %08h",
                           want.address, result_if.data.address);
                    mismatches++;
                end
                if (result_if.data.port_number !== want.port_number)
                begin
                    $error("port_number: expected %0d, got %0d",
                           want.port_number, result_if.data.port_number);
                    mismatches++;
                end
            end
        end
    end

    // Send one character; starts and returns at a falling edge
    task automatic send_char(logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(negedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.data.ch <= c;
        do @(posedge clk); while (!chars_if.ready);
        parse_char(c);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s, bit terminate = 1'b1);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        if (terminate)
            send_char(CH_NUL);
    endtask

    task automatic send_built_text();
        foreach (text_q[i])
            send_char(text_q[i]);
        send_char(CH_NUL);
    endtask

    // Stop offering requests and wait until every expected result is in
    task automatic drain();
        chars_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(int unsigned src_pct, int unsigned sink_pct);
        @(posedge clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        @(negedge clk);
    endtask

    // Append a decimal field of ndig digits, capped at limit; extremes are favored
    task automatic put_field(int unsigned ndig, int unsigned limit);
        int unsigned cap;
        int unsigned val;
        int unsigned scale;
        if (ndig == 0)
            return;
        cap = 1;
        repeat (ndig) cap *= 10;
        cap -= 1;
        if (cap > limit)
            cap = limit;
        case ($urandom_range(3))
            0:       val = cap;
            1:       val = 0;
            default: val = $urandom_range(cap);
        endcase
        scale = 1;
        repeat (ndig - 1) scale *= 10;
        repeat (ndig)
        begin
            text_q.push_back(CH_ZERO + 8'((val / scale) % 10));
            scale /= 10;
        end
    endtask

    task automatic build_good_text();
        text_q.delete();
        for (int k = 0; k < 4; k++)
        begin
            put_field(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3), OCTET_MAX);
            text_q.push_back((k < 3) ? CH_DOT : CH_COLON);
        end
        put_field($urandom_range(1, 5), PORT_MAX);
        // optional path tail, ignored by the parser
        if ($urandom_range(3) == 0)
        begin
            text_q.push_back(CH_SLASH);
            repeat ($urandom_range(4)) text_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    // Mostly well-formed text, some with one defect, a few pure noise
    task automatic build_random_text();
        int unsigned pick;
        int unsigned pos;
        int unsigned ins;
        logic [7:0]  sep;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            text_q.delete();
            repeat ($urandom_range(12))
            begin
                case ($urandom_range(3))
                    0:       text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
                    1:       text_q.push_back(($urandom_range(1)) ? CH_DOT : CH_COLON);
                    default: text_q.push_back(8'($urandom_range(1, 255)));
                endcase
            end
            return;
        end
        build_good_text();
        if (pick < 65)
            return;
        pos = $urandom_range(text_q.size() - 1);
        ins = $urandom_range(text_q.size());
        case ($urandom_range(5))
            0: text_q[pos] = 8'($urandom_range(1, 255));
            1: text_q.insert(ins, 8'($urandom_range(1, 255)));
            2: text_q.insert(ins, CH_ZERO + 8'($urandom_range(9)));
            3: text_q.delete(pos);
            4: while (text_q.size() > pos) void'(text_q.pop_back());
            default:
            begin
                case ($urandom_range(2))
                    0:       sep = CH_DOT;
                    1:       sep = CH_COLON;
                    default: sep = CH_SLASH;
                endcase
                text_q.insert(ins, sep);
            end
        endcase
    endtask

    // Field extremes and each failure path of the grammar
    task automatic test_special_cases();
        set_idling(0, 0);
        send_text("");
        send_text("255.255.255.255:65535");
        send_text("...:0");
        send_text("001.02.3.4:00080/");
        send_text("1.2.3.4.5:1");
        send_text("1.2:80");
        send_text("1/2.3.4:5");
        send_text("0.0.0.0:123456");
        send_text("0.0.0.0:65536");
        send_text("1.2.3.4:");
        send_text("1.2.3.4:/x");
        send_text("1.2.3.4:5:6");
        send_text("256.1.1.1:1");
        send_text("1234.1.1.1:1");
        send_text("1.2.3", 1'b0);
        send_char(8'hFF);
        send_text(".4:1");
        send_text("10.0.0.1:8080/x.y:99");
        send_text("10.0.0.1:8080", 1'b0);
        send_char(CH_SLASH);
        send_char(8'h80);
        send_char(CH_NUL);
        send_text("1.2.3");
        drain();
    endtask

    task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct,
                                       int unsigned n_chars);
        int unsigned chars_start;
        int unsigned res_start;
        set_idling(src_pct, sink_pct);
        chars_start = chars_sent;
        res_start   = results_seen;
        while (chars_sent - chars_start < n_chars || results_seen - res_start < 12)
        begin
            build_random_text();
            send_built_text();
        end
        drain();
    endtask

    // Receiver holds off long enough for the output to fill and the input to stall
    task automatic test_backpressure();
        set_idling(0, 0);
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        repeat (8)
        begin
            build_good_text();
            send_built_text();
        end
        drain();
        repeat (4)
        begin
            build_random_text();
            send_built_text();
        end
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        chars_if.valid = 1'b0;
        chars_if.data  = '0;
        clear_parse();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_special_cases();
        test_random_traffic(0, 0, 120);
        test_random_traffic(63, 0, 120);
        test_random_traffic(0, 63, 120);
        test_random_traffic(13, 13, 120);
        test_backpressure();

        drain();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
